### rtl/core/rtcsc_pkg.sv
// rtcsc_pkg: shared types and constants for the seconds-counter RTC.
// Used by rtcsc_core, the top level rtc_seconds_counter_alarm and the checker.
package rtcsc_pkg;

   // Prescaler and divider width, 4..20
   localparam int PRESCALER_WIDTH = 20;

   localparam int OP_W    = 2;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 16;
   localparam int SEC_W   = 32;
   localparam int IRQ_W   = 3;

   // stream packing
   localparam int REQ_TDATA_W = 24;   // reg_address, write_data, zero fill
   localparam int RSP_TDATA_W = 24;   // read_data, interrupt_line, zero fill

   typedef enum logic [OP_W-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [ADDR_W-1:0] ADDR_CTRL_HIGH = 4'd0;
   localparam logic [ADDR_W-1:0] ADDR_CTRL_LOW  = 4'd1;
   localparam logic [ADDR_W-1:0] ADDR_PRESC_HI  = 4'd2;
   localparam logic [ADDR_W-1:0] ADDR_PRESC_LO  = 4'd3;
   localparam logic [ADDR_W-1:0] ADDR_DIV_HI    = 4'd4;
   localparam logic [ADDR_W-1:0] ADDR_DIV_LO    = 4'd5;
   localparam logic [ADDR_W-1:0] ADDR_CNT_HI    = 4'd6;
   localparam logic [ADDR_W-1:0] ADDR_CNT_LO    = 4'd7;
   localparam logic [ADDR_W-1:0] ADDR_ALARM_HI  = 4'd8;
   localparam logic [ADDR_W-1:0] ADDR_ALARM_LO  = 4'd9;

   // ctrl_low bit positions
   localparam int CTRL_SEC_BIT   = 0;
   localparam int CTRL_ALARM_BIT = 1;
   localparam int CTRL_OVF_BIT   = 2;
   localparam int CTRL_SYNC_BIT  = 3;
   localparam int CTRL_CFG_BIT   = 4;
   localparam int CTRL_WDONE_BIT = 5;

   localparam logic [PRESCALER_WIDTH-1:0] PRESC_RESET = PRESCALER_WIDTH'(32'h0000_8000);
   localparam logic [SEC_W-1:0]           ALARM_RESET = {SEC_W{1'b1}};

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   wdata;
   } item_type;

   typedef struct packed {
      logic                irq;
      logic [DATA_W-1:0]   rdata;
   } result_type;

endpackage

### rtl/core/rtcsc_core.sv
// rtcsc_core: RTC register file, prescaler divider, seconds counter and alarm.
// Applies one word per step and returns its result; uses rtcsc_pkg.
module rtcsc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  rtcsc_pkg::item_type   item,
   output rtcsc_pkg::result_type result
);

   localparam int PW = rtcsc_pkg::PRESCALER_WIDTH;

   logic [rtcsc_pkg::IRQ_W-1:0] irq_en_ff, irq_en_in;
   logic                        sec_flag_ff, sec_flag_in;
   logic                        alarm_flag_ff, alarm_flag_in;
   logic                        ovf_flag_ff, ovf_flag_in;
   logic                        sync_flag_ff, sync_flag_in;
   logic                        cfg_mode_ff, cfg_mode_in;
   logic [PW-1:0]               presc_ff, presc_in;
   logic [PW-1:0]               div_ff, div_in;
   logic [rtcsc_pkg::SEC_W-1:0] sec_cnt_ff, sec_cnt_in;
   logic [rtcsc_pkg::SEC_W-1:0] alarm_ff, alarm_in;

   logic [31:0]                 presc_wide;
   logic [31:0]                 div_wide;
   logic [31:0]                 presc_hi_wr;
   logic [31:0]                 presc_lo_wr;
   logic [rtcsc_pkg::SEC_W-1:0] sec_inc;
   logic [rtcsc_pkg::DATA_W-1:0] rdata;

   assign presc_wide  = 32'(presc_ff);
   assign div_wide    = 32'(div_ff);
   assign presc_hi_wr = {item.wdata, presc_wide[15:0]};
   assign presc_lo_wr = {presc_wide[31:16], item.wdata};
   assign sec_inc     = sec_cnt_ff + 32'd1;

   always_comb begin
      irq_en_in     = irq_en_ff;
      sec_flag_in   = sec_flag_ff;
      alarm_flag_in = alarm_flag_ff;
      ovf_flag_in   = ovf_flag_ff;
      sync_flag_in  = sync_flag_ff;
      cfg_mode_in   = cfg_mode_ff;
      presc_in      = presc_ff;
      div_in        = div_ff;
      sec_cnt_in    = sec_cnt_ff;
      alarm_in      = alarm_ff;
      rdata         = '0;

      case (item.op)
         rtcsc_pkg::OP_READ: begin
            case (item.addr)
               rtcsc_pkg::ADDR_CTRL_HIGH: rdata = 16'(irq_en_ff);
               rtcsc_pkg::ADDR_CTRL_LOW: begin
                  rdata[rtcsc_pkg::CTRL_SEC_BIT]   = sec_flag_ff;
                  rdata[rtcsc_pkg::CTRL_ALARM_BIT] = alarm_flag_ff;
                  rdata[rtcsc_pkg::CTRL_OVF_BIT]   = ovf_flag_ff;
                  rdata[rtcsc_pkg::CTRL_SYNC_BIT]  = sync_flag_ff;
                  rdata[rtcsc_pkg::CTRL_CFG_BIT]   = cfg_mode_ff;
                  rdata[rtcsc_pkg::CTRL_WDONE_BIT] = 1'b1;
               end
               rtcsc_pkg::ADDR_PRESC_HI: rdata = presc_wide[31:16];
               rtcsc_pkg::ADDR_PRESC_LO: rdata = presc_wide[15:0];
               rtcsc_pkg::ADDR_DIV_HI:   rdata = div_wide[31:16];
               rtcsc_pkg::ADDR_DIV_LO:   rdata = div_wide[15:0];
               rtcsc_pkg::ADDR_CNT_HI:   rdata = sec_cnt_ff[31:16];
               rtcsc_pkg::ADDR_CNT_LO:   rdata = sec_cnt_ff[15:0];
               rtcsc_pkg::ADDR_ALARM_HI: rdata = alarm_ff[31:16];
               rtcsc_pkg::ADDR_ALARM_LO: rdata = alarm_ff[15:0];
               default:                  rdata = '0;
            endcase
         end
         rtcsc_pkg::OP_WRITE: begin
            case (item.addr)
               rtcsc_pkg::ADDR_CTRL_HIGH: irq_en_in = item.wdata[rtcsc_pkg::IRQ_W-1:0];
               rtcsc_pkg::ADDR_CTRL_LOW: begin
                  // write 0 to clear a flag, 1 leaves it
                  sec_flag_in   = sec_flag_ff   & item.wdata[rtcsc_pkg::CTRL_SEC_BIT];
                  alarm_flag_in = alarm_flag_ff & item.wdata[rtcsc_pkg::CTRL_ALARM_BIT];
                  ovf_flag_in   = ovf_flag_ff   & item.wdata[rtcsc_pkg::CTRL_OVF_BIT];
                  sync_flag_in  = sync_flag_ff  & item.wdata[rtcsc_pkg::CTRL_SYNC_BIT];
                  cfg_mode_in   = item.wdata[rtcsc_pkg::CTRL_CFG_BIT];
               end
               rtcsc_pkg::ADDR_PRESC_HI: if (cfg_mode_ff) presc_in = presc_hi_wr[PW-1:0];
               rtcsc_pkg::ADDR_PRESC_LO: if (cfg_mode_ff) presc_in = presc_lo_wr[PW-1:0];
               rtcsc_pkg::ADDR_CNT_HI:
                  if (cfg_mode_ff) sec_cnt_in = {item.wdata, sec_cnt_ff[15:0]};
               rtcsc_pkg::ADDR_CNT_LO:
                  if (cfg_mode_ff) sec_cnt_in = {sec_cnt_ff[31:16], item.wdata};
               rtcsc_pkg::ADDR_ALARM_HI:
                  if (cfg_mode_ff) alarm_in = {item.wdata, alarm_ff[15:0]};
               rtcsc_pkg::ADDR_ALARM_LO:
                  if (cfg_mode_ff) alarm_in = {alarm_ff[31:16], item.wdata};
               default: ;
            endcase
         end
         rtcsc_pkg::OP_TICK: begin
            sync_flag_in = 1'b1;
            if (div_ff != '0) begin
               div_in = div_ff - PW'(1);
            end else begin
               // reload and advance one second
               div_in      = presc_ff;
               sec_cnt_in  = sec_inc;
               sec_flag_in = 1'b1;
               if (sec_inc == '0)
                  ovf_flag_in = 1'b1;
               if (sec_inc == alarm_ff)
                  alarm_flag_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // interrupt comes from the state after this word
   assign result.rdata = rdata;
   assign result.irq   = (irq_en_in[0] & sec_flag_in) |
                         (irq_en_in[1] & alarm_flag_in) |
                         (irq_en_in[2] & ovf_flag_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_en_ff     <= '0;
         sec_flag_ff   <= 1'b0;
         alarm_flag_ff <= 1'b0;
         ovf_flag_ff   <= 1'b0;
         sync_flag_ff  <= 1'b0;
         cfg_mode_ff   <= 1'b0;
         presc_ff      <= rtcsc_pkg::PRESC_RESET;
         div_ff        <= rtcsc_pkg::PRESC_RESET;
         sec_cnt_ff    <= '0;
         alarm_ff      <= rtcsc_pkg::ALARM_RESET;
      end else if (step) begin
         irq_en_ff     <= irq_en_in;
         sec_flag_ff   <= sec_flag_in;
         alarm_flag_ff <= alarm_flag_in;
         ovf_flag_ff   <= ovf_flag_in;
         sync_flag_ff  <= sync_flag_in;
         cfg_mode_ff   <= cfg_mode_in;
         presc_ff      <= presc_in;
         div_ff        <= div_in;
         sec_cnt_ff    <= sec_cnt_in;
         alarm_ff      <= alarm_in;
      end
   end

endmodule

### rtl/core/rtc_seconds_counter_alarm.sv
// rtc_seconds_counter_alarm: top level of the seconds-counter RTC.
// Input register, rtcsc_core and result register; uses rtcsc_pkg.
//
//  channel | direction | tdata                              | tuser
//  req_    | in        | [3:0] reg_address [19:4] write_data | [1:0] operation
//  rsp_    | out       | [15:0] read_data [16] interrupt_line| none
//
// One word per cycle sustained while rsp_tready holds; a taken word passes
// through the input register, then the core logic into the result register.
// The core state updates when a word leaves the input register.
// Reset clears both valid bits and all RTC state to its power-on values.
// A stalled result holds; the input register still takes one more word.
module rtc_seconds_counter_alarm (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rtcsc_pkg::REQ_TDATA_W-1:0]   req_tdata,   // reg_address, write_data, zero
   input  logic [rtcsc_pkg::OP_W-1:0]          req_tuser,   // operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rtcsc_pkg::RSP_TDATA_W-1:0]   rsp_tdata    // read_data, interrupt_line, zero
);

   logic                  in_valid_ff, in_valid_in;
   rtcsc_pkg::item_type   in_item_ff;
   logic                  out_valid_ff, out_valid_in;
   rtcsc_pkg::result_type out_res_ff;
   rtcsc_pkg::result_type core_res;
   rtcsc_pkg::item_type   req_item;
   logic                  out_free;
   logic                  advance;
   logic                  req_fire;

   assign req_item.op    = rtcsc_pkg::op_type'(req_tuser);
   assign req_item.addr  = req_tdata[3:0];
   assign req_item.wdata = req_tdata[19:4];

   assign out_free     = !out_valid_ff || rsp_tready;
   assign advance      = in_valid_ff && out_free;
   assign req_tready   = !in_valid_ff || advance;
   assign req_fire     = req_tvalid && req_tready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   rtcsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire)
         in_item_ff <= req_item;
      if (advance)
         out_res_ff <= core_res;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_res_ff.irq, out_res_ff.rdata};

endmodule

### rtl/core/rtcsc_checker.sv
// rtcsc_checker: port-level assertions for rtc_seconds_counter_alarm.
// Attached to the top level by the bind below; uses rtcsc_pkg for widths.
module rtcsc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [rtcsc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [rtcsc_pkg::OP_W-1:0]        req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rtcsc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input only backs up when the result side is full and stalled
   a_ready_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without output backpressure");

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // fill bits above interrupt_line stay zero
   a_rsp_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:17] == 7'd0))
      else $error("result fill bits set");

   // a word accepted into an empty block shows up after the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid && rsp_tready) |=> ##1 rsp_tvalid)
      else $error("result missing after accepted word");

endmodule

bind rtc_seconds_counter_alarm rtcsc_checker u_rtcsc_checker (.*);
